// ===== rtl/core/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/core/cfgd_pkg.sv =====
// package for the tunable-white fader: fixed-point constants, register codes
// and the gamma 2.2 lookup table built at elaboration; no dependencies
`default_nettype none

package cfgd_pkg;

    localparam int LevelFracBits = 16;
    localparam int LevelW        = LevelFracBits + 1;
    localparam int GammaSeg      = 256;
    localparam int GammaIdxBits  = $clog2(GammaSeg);
    localparam int GammaW        = 25;
    localparam int DutyBits      = 12;
    localparam int KelvinW       = 15;
    localparam int TransW        = 20;
    localparam int LenW          = 30;
    localparam int ResW          = 12;
    localparam int DivQBits      = LevelW;

    localparam logic [LevelW-1:0]   LevelOne = LevelW'(1) << LevelFracBits;
    localparam logic [DutyBits-1:0] DutyMax  = '1;
    localparam logic [9:0]          MsToUs   = 10'd1000;
    localparam logic [6:0]          LvlRound = 7'd127;
    // reciprocal of 255, exact for level products below 2^24
    localparam logic [23:0]         LvlRecip      = 24'h808081;
    localparam int                  LvlRecipShift = 31;

    localparam logic CfgWarmKelvin = 1'b0;
    localparam logic CfgColdKelvin = 1'b1;

    typedef logic [GammaSeg:0][GammaW-1:0] t_gamma_tab;

    function automatic t_gamma_tab gamma_build();
        t_gamma_tab      tab;
        longint unsigned x;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        tab = '0;
        for (int i = 0; i <= GammaSeg; i++) begin
            x  = (longint'(i) << 30) / GammaSeg;
            lo = 0;
            hi = 64'd1 << 30;
            for (int s = 0; s < 32; s++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    p   = mid;
                    for (int k = 0; k < 4; k++) begin
                        p = (p * mid) >> 30;
                    end
                    if (p <= x) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            tab[i] = GammaW'(((((x * x) >> 30) * lo) + (64'd1 << 35)) >> 36);
        end
        return tab;
    endfunction

    localparam t_gamma_tab GammaTab = gamma_build();

endpackage

`default_nettype wire

// ===== rtl/core/cct_fade_gamma_dither.sv =====
// Two-channel warm/cold LED fader. A tick request (tuser 0) gives one pair of
// dithered 12-bit duties; a target request (tuser 1) starts a new fade and gives
// no result. The block handles one request at a time with one shared multiplier
// and one 17-step restoring divider; most of the work of a target request lies
// in the divider (one division per fading channel, one for the mired split);
// the level scaling by 255 is a reciprocal multiplication. A finished result
// waits in the output register while the next request is taken; a tick whose
// result finds that register still full holds in its last step until the
// register drains.
// depends on cfgd_pkg
`default_nettype none

module cct_fade_gamma_dither (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wen,
    input  wire logic                         i_cfg_idx,
    input  wire logic [cfgd_pkg::KelvinW-1:0] i_cfg_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_us[31:0], power_on[32], brightness[40:33], kelvin[55:41],
    // transition_ms[75:56], zero fill
    input  wire logic [79:0]                  s_axis_tdata,
    // mode[0]
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // warm_pwm[11:0], cold_pwm[23:12]
    output logic [23:0]                       m_axis_tdata
);
    import cfgd_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE      = 17'h00001,
        S_FADE      = 17'h00002,
        S_FADE_FIN  = 17'h00004,
        S_NUM       = 17'h00008,
        S_DEN       = 17'h00010,
        S_RATIO     = 17'h00020,
        S_RATIO_FIN = 17'h00040,
        S_LVL       = 17'h00080,
        S_LVL_FIN   = 17'h00100,
        S_LEN       = 17'h00200,
        S_COMMIT    = 17'h00400,
        S_GAM       = 17'h00800,
        S_DUTY      = 17'h01000,
        S_DITH      = 17'h02000,
        S_OUT       = 17'h04000,
        S_LOAD      = 17'h08000,
        S_DIV       = 17'h10000
    } t_state;

    localparam int PW = 49;

    t_state r_state;
    t_state r_after;

    logic [KelvinW-1:0] r_kw;
    logic [KelvinW-1:0] r_kc;
    logic [LevelW-1:0]  r_start  [2];
    logic [LevelW-1:0]  r_target [2];
    logic [31:0]        r_fade_start;
    logic [LenW-1:0]    r_len;
    logic [ResW-1:0]    r_res    [2];

    logic               r_mode;
    logic               r_ch;
    logic [31:0]        r_now;
    logic [31:0]        r_elapsed;
    logic [7:0]         r_bright;
    logic [KelvinW-1:0] r_kelvin;
    logic [TransW-1:0]  r_trans;
    logic [LevelW-1:0]  r_lvl    [2];
    logic [LevelW-1:0]  r_tnew   [2];
    logic [LevelW-1:0]  r_ratio;
    logic [29:0]        r_num;
    logic               r_num_neg;
    logic [GammaW-1:0]  r_gbase;
    logic [DutyBits-1:0] r_duty  [2];

    logic [PW-1:0]      r_prod;
    logic [LenW-1:0]    r_div;
    logic [LenW:0]      r_rem;
    logic [DivQBits-1:0] r_lo;
    logic [DivQBits-1:0] r_quo;
    logic [4:0]         r_cnt;

    logic               r_m_tvalid;
    logic [23:0]        r_m_tdata;

    logic [31:0]        m_a;
    logic [31:0]        m_b;
    logic [11:0]        m_add;
    logic [63:0]        w_mprod;
    logic [PW-1:0]      w_mres;

    logic [LevelW-1:0]  w_from;
    logic [LevelW-1:0]  w_to;
    logic               w_up;
    logic [LevelW-1:0]  w_fdiff;
    logic               w_fade_done;

    logic [15:0]        w_kck;
    logic [15:0]        w_kck_mag;
    logic [15:0]        w_kckw;
    logic [15:0]        w_kckw_mag;
    logic               w_den_neg;
    logic [29:0]        w_den;

    logic [LevelW-1:0]  w_lv;
    logic [LevelW-GammaIdxBits-1:0] w_gidx;
    logic               w_gsat;
    logic [LevelFracBits-1:0] w_gfrac;
    logic [GammaW-1:0]  w_ga;
    logic [GammaW-1:0]  w_gb;
    logic [GammaW-1:0]  w_gdiff;
    logic [GammaW-1:0]  w_g;

    logic [23:0]        w_ideal;
    logic signed [25:0] w_v;
    logic signed [25:0] w_vr;
    logic [DutyBits-1:0] w_dc;

    logic [31:0]        w_dstep;
    logic               w_dge;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    // fade operands
    assign w_from      = r_start[r_ch];
    assign w_to        = r_target[r_ch];
    assign w_up        = (w_to >= w_from);
    assign w_fdiff     = w_up ? (w_to - w_from) : (w_from - w_to);
    assign w_fade_done = (r_len == '0) || (r_elapsed >= 32'(r_len));

    // mired split operands, signs kept apart
    assign w_kck      = {1'b0, r_kc} - {1'b0, r_kelvin};
    assign w_kck_mag  = w_kck[15] ? (16'd0 - w_kck) : w_kck;
    assign w_kckw     = {1'b0, r_kc} - {1'b0, r_kw};
    assign w_kckw_mag = w_kckw[15] ? (16'd0 - w_kckw) : w_kckw;
    assign w_den_neg  = w_kckw[15];
    assign w_den      = r_prod[29:0];

    // gamma lookup
    assign w_lv    = r_lvl[r_ch];
    assign w_gidx  = w_lv[LevelW-1:GammaIdxBits];
    assign w_gsat  = (w_gidx >= (LevelW-GammaIdxBits)'(GammaSeg));
    assign w_gfrac = LevelFracBits'({w_lv[GammaIdxBits-1:0], {GammaIdxBits{1'b0}}});
    assign w_ga    = w_gsat ? GammaTab[GammaSeg] : GammaTab[w_gidx];
    assign w_gb    = w_gsat ? GammaTab[GammaSeg] : GammaTab[w_gidx + 1'b1];
    assign w_gdiff = w_gb - w_ga;
    assign w_g     = r_gbase + GammaW'(r_prod[LevelFracBits +: GammaW]);

    // dither
    assign w_ideal = r_prod[12 +: 24];
    assign w_v     = $signed({2'b00, w_ideal}) + 26'(signed'(r_res[r_ch]));
    assign w_vr    = w_v + 26'sd2048;
    always_comb begin
        if (w_vr < 0) begin
            w_dc = '0;
        end else if (w_vr[25:12] > 14'(DutyMax)) begin
            w_dc = DutyMax;
        end else begin
            w_dc = DutyBits'(w_vr[25:12]);
        end
    end

    // divider step
    assign w_dstep = {r_rem, r_lo[DivQBits-1]};
    assign w_dge   = (w_dstep >= 32'(r_div));

    // shared multiplier operands
    always_comb begin
        m_a   = '0;
        m_b   = '0;
        m_add = '0;
        case (r_state)
            S_FADE: begin
                m_a = 32'(w_fdiff);
                m_b = r_elapsed;
            end
            S_NUM: begin
                m_a = 32'(w_kck_mag);
                m_b = 32'(r_kw);
            end
            S_DEN: begin
                m_a = 32'(w_kckw_mag);
                m_b = 32'(r_kelvin);
            end
            S_LVL: begin
                m_a   = 32'(r_bright);
                m_b   = r_ch ? 32'(LevelOne - r_ratio) : 32'(r_ratio);
                m_add = 12'(LvlRound);
            end
            S_LVL_FIN: begin
                m_a = 32'(r_prod[23:0]);
                m_b = 32'(LvlRecip);
            end
            S_LEN: begin
                m_a = 32'(r_trans);
                m_b = 32'(MsToUs);
            end
            S_GAM: begin
                m_a = 32'(w_gdiff);
                m_b = 32'(w_gfrac);
            end
            S_DUTY: begin
                m_a   = 32'(w_g);
                m_b   = 32'(DutyMax);
                m_add = 12'd2048;
            end
            default: begin
                m_a = '0;
            end
        endcase
    end

    assign w_mprod = m_a * m_b;
    assign w_mres  = PW'(w_mprod + 64'(m_add));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_after      <= S_IDLE;
            r_kw         <= KelvinW'(2700);
            r_kc         <= KelvinW'(6500);
            r_start[0]   <= '0;
            r_start[1]   <= '0;
            r_target[0]  <= '0;
            r_target[1]  <= '0;
            r_fade_start <= '0;
            r_len        <= '0;
            r_res[0]     <= '0;
            r_res[1]     <= '0;
            r_m_tvalid   <= 1'b0;
            r_ch         <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_idx)
                    CfgWarmKelvin: r_kw <= i_cfg_data;
                    CfgColdKelvin: r_kc <= i_cfg_data;
                    default:       r_kw <= r_kw;
                endcase
            end

            if ((r_state == S_OUT) && (!r_m_tvalid || m_axis_tready)) begin
                r_m_tvalid <= 1'b1;
            end else if (r_m_tvalid && m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode    <= s_axis_tuser;
                        r_now     <= s_axis_tdata[31:0];
                        r_elapsed <= s_axis_tdata[31:0] - r_fade_start;
                        r_bright  <= s_axis_tdata[32] ? s_axis_tdata[40:33] : 8'd0;
                        r_kelvin  <= s_axis_tdata[55:41];
                        r_trans   <= s_axis_tdata[75:56];
                        r_ch      <= 1'b0;
                        r_state   <= S_FADE;
                    end
                end
                S_FADE: begin
                    if (w_fade_done) begin
                        r_lvl[r_ch] <= w_to;
                        if (!r_ch) begin
                            r_ch    <= 1'b1;
                            r_state <= S_FADE;
                        end else begin
                            r_ch    <= 1'b0;
                            r_state <= r_mode ? S_NUM : S_GAM;
                        end
                    end else begin
                        r_prod  <= w_mres;
                        r_div   <= r_len;
                        r_after <= S_FADE_FIN;
                        r_state <= S_LOAD;
                    end
                end
                S_FADE_FIN: begin
                    r_lvl[r_ch] <= w_up ? (w_from + r_quo) : (w_from - r_quo);
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_FADE;
                    end else begin
                        r_ch    <= 1'b0;
                        r_state <= r_mode ? S_NUM : S_GAM;
                    end
                end
                S_NUM: begin
                    r_num     <= w_mres[29:0];
                    r_num_neg <= w_kck[15];
                    r_state   <= S_DEN;
                end
                S_DEN: begin
                    r_prod  <= w_mres;
                    r_state <= S_RATIO;
                end
                S_RATIO: begin
                    if ((w_den == '0) || (r_num == '0) || (r_num_neg ^ w_den_neg)) begin
                        r_ratio <= '0;
                        r_state <= S_LVL;
                    end else if (r_num >= w_den) begin
                        r_ratio <= LevelOne;
                        r_state <= S_LVL;
                    end else begin
                        r_prod  <= PW'({r_num, {LevelFracBits{1'b0}}}) + PW'(w_den >> 1);
                        r_div   <= w_den;
                        r_after <= S_RATIO_FIN;
                        r_state <= S_LOAD;
                    end
                end
                S_RATIO_FIN: begin
                    r_ratio <= r_quo;
                    r_state <= S_LVL;
                end
                S_LVL: begin
                    r_prod  <= w_mres;
                    r_state <= S_LVL_FIN;
                end
                S_LVL_FIN: begin
                    r_tnew[r_ch] <= w_mres[LvlRecipShift +: LevelW];
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_LVL;
                    end else begin
                        r_ch    <= 1'b0;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_prod  <= w_mres;
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_start[0]   <= r_lvl[0];
                    r_start[1]   <= r_lvl[1];
                    r_target[0]  <= r_tnew[0];
                    r_target[1]  <= r_tnew[1];
                    r_fade_start <= r_now;
                    r_len        <= r_prod[LenW-1:0];
                    r_state      <= S_IDLE;
                end
                S_GAM: begin
                    r_gbase <= w_ga;
                    r_prod  <= w_mres;
                    r_state <= S_DUTY;
                end
                S_DUTY: begin
                    r_prod  <= w_mres;
                    r_state <= S_DITH;
                end
                S_DITH: begin
                    r_duty[r_ch] <= w_dc;
                    r_res[r_ch]  <= w_v[ResW-1:0];
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_GAM;
                    end else begin
                        r_ch    <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_tvalid || m_axis_tready) begin
                        r_m_tdata  <= {r_duty[1], r_duty[0]};
                        r_state    <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    r_rem   <= r_prod[PW-2:DivQBits];
                    r_lo    <= r_prod[DivQBits-1:0];
                    r_cnt   <= 5'(DivQBits);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= w_dge ? (LenW+1)'(w_dstep - 32'(r_div)) : (LenW+1)'(w_dstep);
                    r_lo    <= {r_lo[DivQBits-2:0], 1'b0};
                    r_quo   <= {r_quo[DivQBits-2:0], w_dge};
                    r_cnt   <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= r_after;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cfgd_checker.sv =====
// port-level checks for cct_fade_gamma_dither, bound to the top level
// depends on assert_macros.svh and cfgd_pkg
`default_nettype none
`include "assert_macros.svh"

module cfgd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_cfg_wen,
    input wire logic                         i_cfg_idx,
    input wire logic [cfgd_pkg::KelvinW-1:0] i_cfg_data,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic [79:0]                  s_axis_tdata,
    input wire logic                         s_axis_tuser,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [23:0]                  m_axis_tdata
);

    // busy once a request is taken
    `ASSERT_RST(a_busy_after_req, i_clk, i_rst_n,
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

    // a new result is only loaded as the sequencer returns to idle
    `ASSERT_RST(a_result_from_busy, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

    // nothing pending straight after reset
    `ASSERT_ALL(a_reset_clears, i_clk,
        (i_rst_n && $past(!i_rst_n)) |-> (!m_axis_tvalid && s_axis_tready))

    // stalled result holds
    `ASSERT_RST(a_result_holds, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind cct_fade_gamma_dither cfgd_checker u_cfgd_checker (.*);

`default_nettype wire
